@@ sv/lrupr_pkg.sv @@
// shared types and constants for the lru page replacement block
package lrupr_pkg;

    localparam int FRAMES_MAX_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int CFG_W   = 5;
    localparam int FAULT_W = 16;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [CFG_W-1:0]   FIU_RESET = 5'd4;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // register index, taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_FILL,
        OP_REPLACE
    } op_t;

    typedef struct packed {
        logic look;
        logic clear;
        logic hit_any;
        logic fill_mode;
        logic apply;
        op_t  op;
    } cell_ctl_t;

endpackage

@@ sv/lrupr_cell.sv @@
// one frame cell: page, valid bit and recency rank, chained to its neighbors
module lrupr_cell #(
    parameter int FRAMES_MAX = lrupr_pkg::FRAMES_MAX_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
    parameter int IDX        = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lrupr_pkg::cell_ctl_t                   ctl,
    input  logic [PAGE_BITS-1:0]                   req_page,
    input  logic                                   in_range,
    input  logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] fill_idx,
    input  logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] max_rank,
    input  logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] thr_rank,
    input  logic                                   fnd_i,
    output logic                                   fnd_o,
    input  logic [FRAMES_MAX-1:0]                  seen_i,
    output logic [FRAMES_MAX-1:0]                  seen_o,
    input  logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] pick_idx_i,
    output logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] pick_idx_o,
    input  logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] pick_rank_i,
    output logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] pick_rank_o,
    input  logic [PAGE_BITS-1:0]                   pick_page_i,
    output logic [PAGE_BITS-1:0]                   pick_page_o
);

    localparam int IDX_W = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 valid_reg, valid_next;
    logic [IDX_W-1:0]     rank_reg, rank_next;
    logic                 sel_reg, sel_next;

    logic valid_eff;
    logic elig;
    logic match;
    logic hit_me;
    logic victim;
    logic sel_look;

    // lookup side
    always_comb
    begin
        valid_eff = valid_reg & ~ctl.clear;
        elig      = valid_eff & in_range;
        match     = elig && (page_reg == req_page);
        hit_me    = match & ~fnd_i;
        fnd_o     = fnd_i | match;
        seen_o    = seen_i | (elig ? (FRAMES_MAX'(1) << rank_reg) : '0);
        victim    = elig && (rank_reg == max_rank);
        if (ctl.hit_any)
        begin
            sel_look = hit_me;
        end
        else if (ctl.fill_mode)
        begin
            sel_look = (MY_IDX == fill_idx);
        end
        else
        begin
            sel_look = victim;
        end
    end

    // selected frame hands its index, rank and page down the row
    always_comb
    begin
        pick_idx_o  = pick_idx_i  | (sel_reg ? MY_IDX   : '0);
        pick_rank_o = pick_rank_i | (sel_reg ? rank_reg : '0);
        pick_page_o = pick_page_i | (sel_reg ? page_reg : '0);
    end

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        sel_next   = sel_reg;
        if (ctl.look)
        begin
            sel_next = sel_look;
            if (ctl.clear)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
        end
        if (ctl.apply)
        begin
            case (ctl.op)
                lrupr_pkg::OP_FILL:
                begin
                    if (sel_reg)
                    begin
                        valid_next = 1'b1;
                        rank_next  = '0;
                        page_next  = req_page;
                    end
                    else if (valid_reg)
                    begin
                        rank_next = rank_reg + IDX_W'(1);
                    end
                end
                lrupr_pkg::OP_HIT:
                begin
                    if (sel_reg)
                    begin
                        rank_next = '0;
                    end
                    else if (valid_reg && (rank_reg < thr_rank))
                    begin
                        rank_next = rank_reg + IDX_W'(1);
                    end
                end
                lrupr_pkg::OP_REPLACE:
                begin
                    if (sel_reg)
                    begin
                        rank_next = '0;
                        page_next = req_page;
                    end
                    else if (valid_reg && (rank_reg < thr_rank))
                    begin
                        rank_next = rank_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

@@ sv/lru_page_replacement.sv @@
// lru page replacement unit: control, configuration and a row of frame cells
//
// requests enter on req_valid/req_ready with page and restart; one result per
// item leaves on rsp_valid/rsp_ready with hit, frame, evicted_valid,
// evicted_page and fault_count.
// frames_in_use sits at byte address 0 of the apb port (reset value 4).
// an item passes a lookup state across the cell row (match,
// first-hit chain, oldest-rank search) and then an update state in which the
// selected cell takes the page or becomes newest while valid cells age (on a
// hit or replace only those newer than it). rsp_valid is registered at the
// end of the update. items pass this lookup/update sequence over the shared cell state.
// the next item is accepted in the update cycle of the current one, so the
// result register and the next lookup overlap.
// reset empties all frames, clears the fault count and the fill count.
// if the receiver stalls with a result still held, the update waits and no
// new item is taken until the result register frees up.
module lru_page_replacement #(
    parameter int FRAMES_MAX = lrupr_pkg::FRAMES_MAX_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lrupr_pkg::ADDR_W-1:0]           paddr,
    input  logic [lrupr_pkg::DATA_W-1:0]           pwdata,
    output logic [lrupr_pkg::DATA_W-1:0]           prdata,
    output logic                                   pready,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic [PAGE_BITS-1:0]                   page,
    input  logic                                   restart,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic                                   hit,
    output logic [((FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1)-1:0] frame,
    output logic                                   evicted_valid,
    output logic [PAGE_BITS-1:0]                   evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]          fault_count
);

    localparam int IDX_W = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam int CNT_W = $clog2(FRAMES_MAX + 1);
    localparam int CMP_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;
    localparam int CFG_W = lrupr_pkg::CFG_W;
    localparam int FLT_W = lrupr_pkg::FAULT_W;

    lrupr_pkg::state_t state_reg, state_next;
    lrupr_pkg::op_t    op_reg, op_next, op_look;

    logic [CFG_W-1:0]     fiu_reg, fiu_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [FLT_W-1:0]     fault_reg, fault_next, fault_upd;
    logic [PAGE_BITS-1:0] page_req_reg, page_req_next;
    logic                 restart_reg, restart_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     frame_reg, frame_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0] ev_page_reg, ev_page_next;
    logic [FLT_W-1:0]     fcount_reg, fcount_next;

    logic look_en;
    logic apply_en;
    logic apply_go;
    logic accept;
    logic cfg_wr;

    logic [CMP_W-1:0]      n_eff;
    logic [CMP_W-1:0]      fiu_x;
    logic [CNT_W-1:0]      fill_eff;
    logic                  fill_mode;
    logic [IDX_W-1:0]      fill_idx;
    logic [IDX_W-1:0]      max_rank;
    logic [FRAMES_MAX-1:0] range_vec;

    lrupr_pkg::cell_ctl_t ctl;

    logic                  fnd       [0:FRAMES_MAX];
    logic [FRAMES_MAX-1:0] seen      [0:FRAMES_MAX];
    logic [IDX_W-1:0]      pick_idx  [0:FRAMES_MAX];
    logic [IDX_W-1:0]      pick_rank [0:FRAMES_MAX];
    logic [PAGE_BITS-1:0]  pick_page [0:FRAMES_MAX];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[lrupr_pkg::ADDR_W-1:2] == lrupr_pkg::REG_FRAMES_IN_USE)
                    ? lrupr_pkg::DATA_W'(fiu_reg) : '0;

    always_comb
    begin
        fiu_next = fiu_reg;
        if (cfg_wr && (paddr[lrupr_pkg::ADDR_W-1:2] == lrupr_pkg::REG_FRAMES_IN_USE))
        begin
            fiu_next = pwdata[CFG_W-1:0];
        end
    end

    // control state machine
    assign apply_go = ~rsp_valid_reg | rsp_ready;
    assign accept   = req_valid & req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lrupr_pkg::ST_LOOK;
                end
            end
            lrupr_pkg::ST_LOOK:
            begin
                state_next = lrupr_pkg::ST_APPLY;
            end
            lrupr_pkg::ST_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = req_valid ? lrupr_pkg::ST_LOOK : lrupr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        look_en   = 1'b0;
        apply_en  = 1'b0;
        case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            lrupr_pkg::ST_LOOK:
            begin
                look_en = 1'b1;
            end
            lrupr_pkg::ST_APPLY:
            begin
                req_ready = apply_go;
                apply_en  = apply_go;
            end
            default:
            begin
            end
        endcase
    end

    // working set size and fill position
    always_comb
    begin
        fiu_x = CMP_W'(fiu_reg);
        if (fiu_x == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (fiu_x > CMP_W'(FRAMES_MAX))
        begin
            n_eff = CMP_W'(FRAMES_MAX);
        end
        else
        begin
            n_eff = fiu_x;
        end
        for (int i = 0; i < FRAMES_MAX; i++)
        begin
            range_vec[i] = (CMP_W'(i) < n_eff);
        end
        fill_eff  = restart_reg ? '0 : fill_reg;
        fill_mode = (CMP_W'(fill_eff) < n_eff);
        fill_idx  = fill_eff[IDX_W-1:0];
    end

    // oldest rank present among frames in use
    always_comb
    begin
        max_rank = '0;
        for (int i = 0; i < FRAMES_MAX; i++)
        begin
            if (seen[FRAMES_MAX][i])
            begin
                max_rank = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        ctl.look      = look_en;
        ctl.clear     = restart_reg;
        ctl.hit_any   = fnd[FRAMES_MAX];
        ctl.fill_mode = fill_mode;
        ctl.apply     = apply_en;
        ctl.op        = op_reg;
    end

    assign fnd[0]       = 1'b0;
    assign seen[0]      = '0;
    assign pick_idx[0]  = '0;
    assign pick_rank[0] = '0;
    assign pick_page[0] = '0;

    for (genvar g = 0; g < FRAMES_MAX; g++)
    begin : g_cell
        lrupr_cell #(
            .FRAMES_MAX (FRAMES_MAX),
            .PAGE_BITS  (PAGE_BITS),
            .IDX        (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .req_page    (page_req_reg),
            .in_range    (range_vec[g]),
            .fill_idx    (fill_idx),
            .max_rank    (max_rank),
            .thr_rank    (pick_rank[FRAMES_MAX]),
            .fnd_i       (fnd[g]),
            .fnd_o       (fnd[g+1]),
            .seen_i      (seen[g]),
            .seen_o      (seen[g+1]),
            .pick_idx_i  (pick_idx[g]),
            .pick_idx_o  (pick_idx[g+1]),
            .pick_rank_i (pick_rank[g]),
            .pick_rank_o (pick_rank[g+1]),
            .pick_page_i (pick_page[g]),
            .pick_page_o (pick_page[g+1])
        );
    end

    // item bookkeeping
    always_comb
    begin
        if (fnd[FRAMES_MAX])
        begin
            op_look = lrupr_pkg::OP_HIT;
        end
        else if (fill_mode)
        begin
            op_look = lrupr_pkg::OP_FILL;
        end
        else
        begin
            op_look = lrupr_pkg::OP_REPLACE;
        end

        if ((op_reg == lrupr_pkg::OP_HIT) || (fault_reg == lrupr_pkg::FAULT_MAX))
        begin
            fault_upd = fault_reg;
        end
        else
        begin
            fault_upd = fault_reg + FLT_W'(1);
        end

        page_req_next  = page_req_reg;
        restart_next   = restart_reg;
        op_next        = op_reg;
        fill_next      = fill_reg;
        fault_next     = fault_reg;
        rsp_valid_next = rsp_valid_reg;
        hit_next       = hit_reg;
        frame_next     = frame_reg;
        ev_valid_next  = ev_valid_reg;
        ev_page_next   = ev_page_reg;
        fcount_next    = fcount_reg;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (look_en)
        begin
            op_next = op_look;
            if (restart_reg)
            begin
                fill_next  = '0;
                fault_next = '0;
            end
        end

        if (apply_en)
        begin
            if (op_reg == lrupr_pkg::OP_FILL)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            fault_next     = fault_upd;
            rsp_valid_next = 1'b1;
            hit_next       = (op_reg == lrupr_pkg::OP_HIT);
            frame_next     = pick_idx[FRAMES_MAX];
            ev_valid_next  = (op_reg == lrupr_pkg::OP_REPLACE);
            ev_page_next   = (op_reg == lrupr_pkg::OP_REPLACE) ? pick_page[FRAMES_MAX] : '0;
            fcount_next    = fault_upd;
        end

        if (accept)
        begin
            page_req_next = page;
            restart_next  = restart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrupr_pkg::ST_IDLE;
            op_reg        <= lrupr_pkg::OP_HIT;
            fiu_reg       <= lrupr_pkg::FIU_RESET;
            fill_reg      <= '0;
            fault_reg     <= '0;
            restart_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            fiu_reg       <= fiu_next;
            fill_reg      <= fill_next;
            fault_reg     <= fault_next;
            restart_reg   <= restart_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_req_reg <= page_req_next;
        hit_reg      <= hit_next;
        frame_reg    <= frame_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
        fcount_reg   <= fcount_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign hit           = hit_reg;
    assign frame         = frame_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fcount_reg;

`ifndef SYNTHESIS
    a_look_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrupr_pkg::ST_LOOK) |=> (state_reg == lrupr_pkg::ST_APPLY))
        else $error("lookup not followed by update");

    a_fill_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lrupr_pkg::ST_APPLY) && (op_reg == lrupr_pkg::OP_FILL))
        |-> (fill_reg < CNT_W'(FRAMES_MAX)))
        else $error("fill past last frame");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && restart)
        |=> ##1 ((fill_reg == '0) && (fault_reg == '0)))
        else $error("restart did not clear fill and fault counts");

    a_hit_keeps_faults: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_en && (op_reg == lrupr_pkg::OP_HIT)) |=> (fault_reg == $past(fault_reg)))
        else $error("fault count changed on a hit");
`endif

endmodule
